// ===== hdl/rcpp_pkg.sv =====
// Shared types and constants for the robot command packet parser.
// Used by the front parser, the command queue, the back executor and the top level.
package rcpp_pkg;

  // Packet framing
  localparam int unsigned JOY_PACKET_LEN    = 14;
  localparam int unsigned BUTTON_PACKET_LEN = 2;
  localparam int unsigned QUEUE_DEPTH       = 4;

  localparam int unsigned COUNT_W = 9;

  localparam logic [7:0] CHAR_JOY    = 8'h53;  // 'S'
  localparam logic [7:0] CHAR_BUTTON = 8'h42;  // 'B'
  localparam logic [7:0] CHAR_PARAM  = 8'h50;  // 'P'
  localparam logic [7:0] CHAR_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CHAR_GAIN_UP   = 8'h31;  // '1'
  localparam logic [7:0] CHAR_GAIN_DOWN = 8'h32;  // '2'
  localparam logic [7:0] CHAR_ESTOP     = 8'h33;  // '3'

  localparam logic signed [16:0] AXIS_CENTER = 17'sd512;

  // Reset values of the configuration registers
  localparam logic [6:0]  START_GAIN_RST = 7'd10;
  localparam logic [7:0]  TURN_GAIN_RST  = 8'd1;
  localparam logic [15:0] TURN_ATTEN_RST = 16'd1000;

  localparam logic [6:0] GAIN_MAX = 7'd127;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_START_GAIN = 2'd0,
    REG_TURN_GAIN  = 2'd1,
    REG_TURN_ATTEN = 2'd2
  } reg_index_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_DRIVE       = 3'd0,
    KIND_GAIN        = 3'd1,
    KIND_ESTOP       = 3'd2,
    KIND_PARAM_BYTE  = 3'd3,
    KIND_PARAM_EMPTY = 3'd4
  } kind_t;

  // Configuration write request
  typedef struct packed {
    logic        valid;
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_wr_t;

  // Turn settings used by the executor
  typedef struct packed {
    logic [7:0]  gain;
    logic [15:0] atten;
  } turn_cfg_t;

  // One classified command between front and back
  typedef struct packed {
    kind_t       kind;
    logic [15:0] x_axis;
    logic [15:0] y_axis;
    logic [6:0]  gain;
    logic [7:0]  tag;
    logic [7:0]  length;
    logic [7:0]  index;
    logic [7:0]  data;
    logic        last;
  } cmd_t;

endpackage

// ===== hdl/rcpp_front.sv =====
// Front parser: frames received bytes into packets and classifies them.
// Depends on rcpp_pkg; pushes one rcpp_pkg::cmd_t per result into the queue.
module rcpp_front #(
  parameter int unsigned JOY_LEN = rcpp_pkg::JOY_PACKET_LEN,
  parameter int unsigned BTN_LEN = rcpp_pkg::BUTTON_PACKET_LEN
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [7:0]       rx_byte,
  input  rcpp_pkg::cfg_wr_t cfg,
  output logic             q_push,
  output rcpp_pkg::cmd_t   q_entry
);

  typedef enum logic [3:0] {
    PH_WAIT = 4'b0001,
    PH_JOY  = 4'b0010,
    PH_BTN  = 4'b0100,
    PH_PAR  = 4'b1000
  } phase_t;

  localparam int unsigned CW = rcpp_pkg::COUNT_W;

  phase_t          phase, phase_next;
  logic [CW-1:0]   byte_count, byte_count_next;
  logic [15:0]     x_accum, x_accum_next;
  logic [15:0]     y_accum, y_accum_next;
  logic [7:0]      tag_hold, tag_hold_next;
  logic [7:0]      length_hold, length_hold_next;
  logic [6:0]      gain_now, gain_now_next;

  logic [CW:0]     pos_plus;
  logic [7:0]      button;
  logic [7:0]      value_index;
  logic            value_final;

  function automatic logic [15:0] digit_acc(input logic [15:0] acc, input logic [7:0] b);
    digit_acc = 16'((acc << 3) + (acc << 1)) + {8'd0, b} - {8'd0, rcpp_pkg::CHAR_ZERO};
  endfunction

  assign pos_plus    = {1'b0, byte_count} + (CW+1)'(1);
  assign button      = (byte_count == CW'(1)) ? rx_byte : tag_hold;
  assign value_index = 8'(byte_count - CW'(3));
  assign value_final = ({1'b0, value_index} + 9'd1) >= {1'b0, length_hold};

  // Parse one byte
  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    x_accum_next     = x_accum;
    y_accum_next     = y_accum;
    tag_hold_next    = tag_hold;
    length_hold_next = length_hold;
    gain_now_next    = gain_now;
    q_push           = 1'b0;
    q_entry          = '0;
    q_entry.kind     = rcpp_pkg::KIND_DRIVE;

    if (in_valid) begin
      unique case (phase)
        PH_WAIT: begin
          priority if (rx_byte == rcpp_pkg::CHAR_JOY) begin
            phase_next = PH_JOY;
          end else if (rx_byte == rcpp_pkg::CHAR_BUTTON) begin
            phase_next = PH_BTN;
          end else if (rx_byte == rcpp_pkg::CHAR_PARAM) begin
            phase_next = PH_PAR;
          end else begin
            // drop a stray byte
            phase_next = PH_WAIT;
          end
          if (rx_byte == rcpp_pkg::CHAR_JOY || rx_byte == rcpp_pkg::CHAR_BUTTON ||
              rx_byte == rcpp_pkg::CHAR_PARAM) begin
            byte_count_next = CW'(1);
            x_accum_next    = '0;
            y_accum_next    = '0;
          end
        end
        PH_JOY: begin
          byte_count_next = byte_count + CW'(1);
          if (byte_count >= CW'(1) && byte_count <= CW'(4)) begin
            x_accum_next = digit_acc(x_accum, rx_byte);
          end
          if (byte_count >= CW'(8) && byte_count <= CW'(11)) begin
            y_accum_next = digit_acc(y_accum, rx_byte);
          end
          if (pos_plus >= (CW+1)'(JOY_LEN)) begin
            phase_next      = PH_WAIT;
            byte_count_next = '0;
            q_push          = 1'b1;
            q_entry.kind    = rcpp_pkg::KIND_DRIVE;
            q_entry.x_axis  = x_accum_next;
            q_entry.y_axis  = y_accum_next;
            q_entry.gain    = gain_now;
          end
        end
        PH_BTN: begin
          byte_count_next = byte_count + CW'(1);
          if (byte_count == CW'(1)) begin
            tag_hold_next = rx_byte;
          end
          if (pos_plus >= (CW+1)'(BTN_LEN)) begin
            phase_next      = PH_WAIT;
            byte_count_next = '0;
            priority if (button == rcpp_pkg::CHAR_GAIN_UP) begin
              if (gain_now != rcpp_pkg::GAIN_MAX) begin
                gain_now_next = gain_now + 7'd1;
              end
              q_push       = 1'b1;
              q_entry.kind = rcpp_pkg::KIND_GAIN;
            end else if (button == rcpp_pkg::CHAR_GAIN_DOWN) begin
              if (gain_now != 7'd0) begin
                gain_now_next = gain_now - 7'd1;
              end
              q_push       = 1'b1;
              q_entry.kind = rcpp_pkg::KIND_GAIN;
            end else if (button == rcpp_pkg::CHAR_ESTOP) begin
              q_push       = 1'b1;
              q_entry.kind = rcpp_pkg::KIND_ESTOP;
            end else begin
              // ignore other button codes
              q_push = 1'b0;
            end
            q_entry.gain = gain_now_next;
          end
        end
        PH_PAR: begin
          byte_count_next = byte_count + CW'(1);
          priority if (byte_count == CW'(1)) begin
            tag_hold_next = rx_byte;
          end else if (byte_count == CW'(2)) begin
            length_hold_next = rx_byte;
            if (rx_byte == 8'd0) begin
              phase_next      = PH_WAIT;
              byte_count_next = '0;
              q_push          = 1'b1;
              q_entry.kind    = rcpp_pkg::KIND_PARAM_EMPTY;
              q_entry.tag     = tag_hold;
              q_entry.last    = 1'b1;
              q_entry.gain    = gain_now;
            end
          end else begin
            q_push         = 1'b1;
            q_entry.kind   = rcpp_pkg::KIND_PARAM_BYTE;
            q_entry.tag    = tag_hold;
            q_entry.length = length_hold;
            q_entry.index  = value_index;
            q_entry.data   = rx_byte;
            q_entry.last   = value_final;
            q_entry.gain   = gain_now;
            if (value_final) begin
              phase_next      = PH_WAIT;
              byte_count_next = '0;
            end
          end
        end
        default: begin
          phase_next      = PH_WAIT;
          byte_count_next = '0;
        end
      endcase
    end

    // Load the gain on a start gain write
    if (cfg.valid && cfg.index == rcpp_pkg::REG_START_GAIN) begin
      gain_now_next = cfg.data[6:0];
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_WAIT;
      byte_count  <= '0;
      x_accum     <= '0;
      y_accum     <= '0;
      tag_hold    <= '0;
      length_hold <= '0;
      gain_now    <= rcpp_pkg::START_GAIN_RST;
    end else begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      x_accum     <= x_accum_next;
      y_accum     <= y_accum_next;
      tag_hold    <= tag_hold_next;
      length_hold <= length_hold_next;
      gain_now    <= gain_now_next;
    end
  end

endmodule

// ===== hdl/rcpp_queue.sv =====
// Short command queue between the front parser and the back executor.
// Depends on rcpp_pkg for the command type.
module rcpp_queue #(
  parameter int unsigned DEPTH = rcpp_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  rcpp_pkg::cmd_t wr_data,
  input  logic           rd_en,
  output rcpp_pkg::cmd_t rd_data,
  output logic           q_full,
  output logic           q_empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  rcpp_pkg::cmd_t entries [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW-1:0]  rd_ptr_next;
  logic [NW-1:0]  fill;
  logic           wr_take;
  logic           rd_take;

  assign q_full      = (fill == NW'(DEPTH));
  assign q_empty     = (fill == '0);
  assign wr_take     = wr_en && !q_full;
  assign rd_take     = rd_en && !q_empty;
  assign rd_ptr_next = rd_take ? ((rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1)) : rd_ptr;

  // Store a request
  always_ff @(posedge clk) begin
    if (wr_take) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Register the next head; pass a request through when it lands there
  always_ff @(posedge clk) begin
    if (wr_take && wr_ptr == rd_ptr_next) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= entries[rd_ptr_next];
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_take) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      rd_ptr <= rd_ptr_next;
      if (wr_take && !rd_take) begin
        fill <= fill + NW'(1);
      end else if (!wr_take && rd_take) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule

// ===== hdl/rcpp_back.sv =====
// Back executor: turns queued commands into results, computing drive velocity
// and attenuated turn rate with two multiply steps and a radix-2 divider.
// Depends on rcpp_pkg; drives the result register seen at the top level.
module rcpp_back (
  input  logic                clk,
  input  logic                rst,
  input  rcpp_pkg::turn_cfg_t tcfg,
  input  logic                q_empty,
  input  rcpp_pkg::cmd_t      q_data,
  output logic                q_pop,
  input  logic                out_pop,
  output logic                out_valid,
  output rcpp_pkg::cmd_t      out_cmd,
  output logic [24:0]         out_velocity,
  output logic [24:0]         out_turn
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_NUM  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  localparam int unsigned QW = 41;  // numerator magnitude
  localparam int unsigned DW = 26;  // denominator
  localparam int unsigned SW = $clog2(QW);

  state_t              state;
  rcpp_pkg::cmd_t      hold;
  logic signed [24:0]  velocity;
  logic signed [25:0]  y_scaled;
  logic [DW-1:0]       denom;
  logic [QW-1:0]       quot;
  logic [DW-1:0]       remain;
  logic                negative;
  logic [SW-1:0]       step;

  logic                out_free;
  logic signed [16:0]  x_cent;
  logic signed [16:0]  y_cent;
  logic [16:0]         atten;
  logic signed [41:0]  numer;
  logic [24:0]         vel_mag;
  logic [DW:0]         rem_shift;
  logic                rem_ge;
  logic [QW-1:0]       quot_signed;

  assign out_free = !out_valid || out_pop;
  assign q_pop    = (state == ST_IDLE) && !q_empty && out_free;

  assign x_cent   = 17'(signed'(hold.x_axis)) - rcpp_pkg::AXIS_CENTER;
  assign y_cent   = 17'(signed'(hold.y_axis)) - rcpp_pkg::AXIS_CENTER;
  assign atten    = (tcfg.atten == 16'd0) ? 17'd1 : {1'b0, tcfg.atten};
  assign numer    = 42'(y_scaled * signed'(atten));
  assign vel_mag  = velocity[24] ? 25'(-velocity) : 25'(velocity);

  assign rem_shift   = {remain, quot[QW-1]};
  assign rem_ge      = rem_shift >= {1'b0, denom};
  assign quot_signed = negative ? QW'(-quot) : quot;

  // Sequence one command
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_pop && q_data.kind == rcpp_pkg::KIND_DRIVE) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: state <= ST_NUM;
        ST_NUM: state <= ST_DIV;
        ST_DIV: begin
          if (step == SW'(QW - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath for the drive computation
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (q_pop) begin
          hold <= q_data;
        end
        step <= '0;
      end
      ST_MUL: begin
        velocity <= 25'(x_cent * signed'({1'b0, hold.gain}));
        y_scaled <= 26'(y_cent * signed'({1'b0, tcfg.gain}));
      end
      ST_NUM: begin
        negative <= numer[41];
        quot     <= numer[41] ? QW'(-numer) : QW'(numer);
        denom    <= DW'(atten) + DW'(vel_mag);
        remain   <= '0;
      end
      ST_DIV: begin
        remain <= rem_ge ? DW'(rem_shift - {1'b0, denom}) : DW'(rem_shift);
        quot   <= {quot[QW-2:0], rem_ge};
        step   <= step + SW'(1);
      end
      ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((q_pop && q_data.kind != rcpp_pkg::KIND_DRIVE) || state == ST_FIN) begin
      out_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.kind != rcpp_pkg::KIND_DRIVE) begin
      out_cmd      <= q_data;
      out_velocity <= '0;
      out_turn     <= '0;
    end else if (state == ST_FIN) begin
      out_cmd      <= hold;
      out_velocity <= velocity;
      out_turn     <= quot_signed[24:0];
    end
  end

endmodule

// ===== hdl/robot_command_packet_parser_top.sv =====
// Robot command packet parser, top level: front parser, command queue, back executor.
// Depends on rcpp_pkg, rcpp_front, rcpp_queue and rcpp_back.
// Gain, stop and parameter results pass the queue head and result registers; drives also
// pass two multiply steps and 41 divide steps; no new command is taken until it is done.
// Throughput: one byte per cycle while the queue has room.
// Synchronous reset clears control state and loads the register reset values.
module robot_command_packet_parser_top #(
  parameter int unsigned JOY_LEN     = rcpp_pkg::JOY_PACKET_LEN,
  parameter int unsigned BTN_LEN     = rcpp_pkg::BUTTON_PACKET_LEN,
  parameter int unsigned QUEUE_DEPTH = rcpp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind,
  output logic signed [24:0] forward_velocity,
  output logic signed [24:0] turn_rate,
  output logic [6:0]  vel_gain,
  output logic [7:0]  param_tag,
  output logic [7:0]  param_size,
  output logic [7:0]  param_index,
  output logic [7:0]  param_byte,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  rcpp_pkg::cfg_wr_t   cfg;
  rcpp_pkg::turn_cfg_t tcfg;
  logic                accept;
  logic                q_push;
  rcpp_pkg::cmd_t      q_wr;
  rcpp_pkg::cmd_t      q_rd;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  logic                out_valid;
  logic                out_take;
  rcpp_pkg::cmd_t      out_cmd;
  logic [24:0]         out_velocity;
  logic [24:0]         out_turn;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign full     = q_full;
  assign accept   = push && !q_full;
  assign empty    = !out_valid;
  assign out_take = pop && out_valid;

  // Hold the turn settings
  always_ff @(posedge clk) begin
    if (rst) begin
      tcfg.gain  <= rcpp_pkg::TURN_GAIN_RST;
      tcfg.atten <= rcpp_pkg::TURN_ATTEN_RST;
    end else if (cfg.valid) begin
      if (cfg.index == rcpp_pkg::REG_TURN_GAIN) begin
        tcfg.gain <= cfg.data[7:0];
      end
      if (cfg.index == rcpp_pkg::REG_TURN_ATTEN) begin
        tcfg.atten <= cfg.data;
      end
    end
  end

  rcpp_front #(
    .JOY_LEN (JOY_LEN),
    .BTN_LEN (BTN_LEN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .rx_byte  (rx_byte),
    .cfg      (cfg),
    .q_push   (q_push),
    .q_entry  (q_wr)
  );

  rcpp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  rcpp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .tcfg         (tcfg),
    .q_empty      (q_empty),
    .q_data       (q_rd),
    .q_pop        (q_pop),
    .out_pop      (out_take),
    .out_valid    (out_valid),
    .out_cmd      (out_cmd),
    .out_velocity (out_velocity),
    .out_turn     (out_turn)
  );

  assign kind             = out_cmd.kind;
  assign forward_velocity = out_velocity;
  assign turn_rate        = out_turn;
  assign vel_gain         = out_cmd.gain;
  assign param_tag        = out_cmd.tag;
  assign param_size       = out_cmd.length;
  assign param_index      = out_cmd.index;
  assign param_byte       = out_cmd.data;
  assign last             = out_cmd.last;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for robot_command_packet_parser_top: bytes in, commands out.
// Depends on rcpp_pkg and the parser RTL. A model of the parser predicts each command, or a
// directed row gives it; each command that comes out is compared field by field with it.
module tb;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 100;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned PHASE_BYTES    = 170;
  localparam int unsigned NUM_PHASES     = 6;

  typedef enum logic [3:0] {
    PS_WAIT   = 4'b0001,
    PS_JOY    = 4'b0010,
    PS_BUTTON = 4'b0100,
    PS_PARAM  = 4'b1000
  } parse_state_t;

  typedef struct packed {
    rcpp_pkg::kind_t kind;
    logic [24:0] fwd;
    logic [24:0] turn;
    logic [6:0]  gain;
    logic [7:0]  tag;
    logic [7:0]  len;
    logic [7:0]  idx;
    logic [7:0]  data;
    logic        last;
  } command_t;

  typedef struct {
    logic [7:0] rx;
    bit         typed;
    command_t   want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [7:0]         rx_byte = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [2:0]         kind;
  logic signed [24:0] forward_velocity;
  logic signed [24:0] turn_rate;
  logic [6:0]         vel_gain;
  logic [7:0]         param_tag;
  logic [7:0]         param_size;
  logic [7:0]         param_index;
  logic [7:0]         param_byte;
  logic               last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  rcpp_pkg::reg_index_t cfg_index = rcpp_pkg::REG_START_GAIN;
  logic [15:0]        cfg_data = '0;

  robot_command_packet_parser_top dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .rx_byte(rx_byte),
    .empty(empty), .pop(pop),
    .kind(kind), .forward_velocity(forward_velocity), .turn_rate(turn_rate),
    .vel_gain(vel_gain), .param_tag(param_tag), .param_size(param_size),
    .param_index(param_index), .param_byte(param_byte), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Parser model state and its copy of the registers
  parse_state_t ps = PS_WAIT;
  logic [8:0]   ps_count = '0;
  logic [15:0]  x_acc = '0;
  logic [15:0]  y_acc = '0;
  logic [7:0]   tag_q = '0;
  logic [7:0]   len_q = '0;
  logic [6:0]   gain_q = rcpp_pkg::START_GAIN_RST;
  logic [7:0]   turn_gain_q = rcpp_pkg::TURN_GAIN_RST;
  logic [15:0]  atten_q = rcpp_pkg::TURN_ATTEN_RST;

  command_t  pending_cmds[$];
  stim_row_t directed_rows[$];

  int err_cnt = 0;
  int bytes_sent = 0;
  int n_drive = 0, n_gain = 0, n_estop = 0, n_param = 0;
  int settings_used = 1;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  int unsigned hold_reqs = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_tick = 0;
  int unsigned idle_cycles = 0;

  // Advance the parser model by one byte; return the command it completes, if any
  task automatic decode_byte(input logic [7:0] b, output bit got, output command_t c);
    logic [8:0] pos;
    logic [7:0] idx;
    longint vel, mag, att, num, trn;
    got = 1'b0;
    c = '0;
    pos = ps_count;
    if (ps == PS_WAIT) begin
      case (b)
        rcpp_pkg::CHAR_JOY:    ps = PS_JOY;
        rcpp_pkg::CHAR_BUTTON: ps = PS_BUTTON;
        rcpp_pkg::CHAR_PARAM:  ps = PS_PARAM;
        default:               return;
      endcase
      ps_count = 9'd1;
      x_acc = '0;
      y_acc = '0;
      return;
    end
    ps_count = ps_count + 9'd1;
    case (ps)
      PS_JOY: begin
        if (pos >= 1 && pos <= 4) x_acc = x_acc * 16'd10 + {8'd0, b} - 16'd48;
        if (pos >= 8 && pos <= 11) y_acc = y_acc * 16'd10 + {8'd0, b} - 16'd48;
        if (pos + 1 >= rcpp_pkg::JOY_PACKET_LEN) begin
          vel = (longint'($signed(x_acc)) - 512) * longint'(gain_q);
          att = (atten_q == 16'd0) ? 64'sd1 : longint'(atten_q);
          mag = (vel < 0) ? -vel : vel;
          num = (longint'($signed(y_acc)) - 512) * longint'(turn_gain_q) * att;
          trn = num / (att + mag);
          c.kind = rcpp_pkg::KIND_DRIVE;
          c.fwd = vel[24:0];
          c.turn = trn[24:0];
          got = 1'b1;
          ps = PS_WAIT;
          ps_count = '0;
        end
      end
      PS_BUTTON: begin
        if (pos == 1) tag_q = b;
        if (pos + 1 >= rcpp_pkg::BUTTON_PACKET_LEN) begin
          ps = PS_WAIT;
          ps_count = '0;
          if (tag_q == rcpp_pkg::CHAR_GAIN_UP) begin
            if (gain_q < rcpp_pkg::GAIN_MAX) gain_q = gain_q + 7'd1;
            c.kind = rcpp_pkg::KIND_GAIN;
            got = 1'b1;
          end else if (tag_q == rcpp_pkg::CHAR_GAIN_DOWN) begin
            if (gain_q > 7'd0) gain_q = gain_q - 7'd1;
            c.kind = rcpp_pkg::KIND_GAIN;
            got = 1'b1;
          end else if (tag_q == rcpp_pkg::CHAR_ESTOP) begin
            c.kind = rcpp_pkg::KIND_ESTOP;
            got = 1'b1;
          end
        end
      end
      default: begin
        if (pos == 1) begin
          tag_q = b;
        end else if (pos == 2) begin
          len_q = b;
          // a zero length closes the packet at once
          if (b == 8'd0) begin
            c.kind = rcpp_pkg::KIND_PARAM_EMPTY;
            c.tag = tag_q;
            c.last = 1'b1;
            got = 1'b1;
            ps = PS_WAIT;
            ps_count = '0;
          end
        end else begin
          idx = pos[7:0] - 8'd3;
          c.kind = rcpp_pkg::KIND_PARAM_BYTE;
          c.tag = tag_q;
          c.len = len_q;
          c.idx = idx;
          c.data = b;
          c.last = (int'(idx) + 1 >= int'(len_q));
          got = 1'b1;
          if (c.last) begin
            ps = PS_WAIT;
            ps_count = '0;
          end
        end
      end
    endcase
    c.gain = gain_q;
  endtask

  function automatic command_t mk_cmd(rcpp_pkg::kind_t k, logic [6:0] g, logic [7:0] tag,
                                      logic [7:0] len, logic [7:0] idx, logic [7:0] data,
                                      logic lst);
    command_t c;
    c = '0;
    c.kind = k;
    c.gain = g;
    c.tag = tag;
    c.len = len;
    c.idx = idx;
    c.data = data;
    c.last = lst;
    return c;
  endfunction

  task automatic add_row(input logic [7:0] rx, input bit typed = 1'b0,
                         input command_t want = '0);
    stim_row_t r;
    r.rx = rx;
    r.typed = typed;
    r.want = want;
    directed_rows.push_back(r);
  endtask

  // Offer one byte; open a random gap at the end of each burst
  task automatic send_byte(input logic [7:0] b, input bit typed, input command_t want);
    bit got;
    command_t c;
    int gap;
    if (!no_gaps && burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 32);
    end
    if (burst_left > 0) burst_left--;
    push <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    bytes_sent++;
    decode_byte(b, got, c);
    if (typed) begin
      if (!got) begin
        $display("%0t: byte %h should close a packet, model gives no command", $time, b);
        err_cnt++;
      end
      c = want;
    end
    if (got) pending_cmds.push_back(c);
  endtask

  task automatic feed(input logic [7:0] b);
    send_byte(b, 1'b0, '0);
  endtask

  // Hold the sender until every predicted command is out, then let the block go quiet
  task automatic drain();
    push <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input rcpp_pkg::reg_index_t idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rcpp_pkg::REG_START_GAIN: gain_q = data[6:0];
      rcpp_pkg::REG_TURN_GAIN:  turn_gain_q = data[7:0];
      default:                  atten_q = data;
    endcase
  endtask

  task automatic configure(input logic [6:0] g, input logic [7:0] tg, input logic [15:0] at);
    cfg_write(rcpp_pkg::REG_START_GAIN, {9'($urandom), g});
    cfg_write(rcpp_pkg::REG_TURN_GAIN, {8'($urandom), tg});
    cfg_write(rcpp_pkg::REG_TURN_ATTEN, at);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Axis digit: all nines, all zeros, any byte, or a random digit
  function automatic logic [7:0] axis_char(int mode);
    case (mode)
      0:       return rcpp_pkg::CHAR_ZERO + 8'd9;
      1:       return rcpp_pkg::CHAR_ZERO;
      2:       return 8'($urandom);
      default: return rcpp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
    endcase
  endfunction

  // Mostly well-formed packets with random content, some noise in between
  task automatic send_random_packet();
    int sel, r, n, xm, ym;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      xm = $urandom_range(0, 9);
      ym = $urandom_range(0, 9);
      feed(rcpp_pkg::CHAR_JOY);
      for (int p = 1; p < rcpp_pkg::JOY_PACKET_LEN; p++) begin
        if (p >= 1 && p <= 4) feed(axis_char(xm));
        else if (p >= 8 && p <= 11) feed(axis_char(ym));
        else feed(8'($urandom));
      end
    end else if (sel < 55) begin
      r = $urandom_range(0, 99);
      feed(rcpp_pkg::CHAR_BUTTON);
      if (r < 40) feed(rcpp_pkg::CHAR_GAIN_UP);
      else if (r < 70) feed(rcpp_pkg::CHAR_GAIN_DOWN);
      else if (r < 85) feed(rcpp_pkg::CHAR_ESTOP);
      else feed(8'($urandom));
    end else if (sel < 82) begin
      r = $urandom_range(0, 99);
      n = (r < 10) ? 0 : (r < 96) ? $urandom_range(1, 8) : $urandom_range(9, 255);
      feed(rcpp_pkg::CHAR_PARAM);
      feed(8'($urandom));
      feed(8'(n));
      repeat (n) feed(8'($urandom));
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) feed(8'($urandom));
    end
  endtask

  // Receiver: switch between stall patterns; serve long hold requests
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_reqs) begin
      holds_served <= holds_served + 1;
      hold_left <= LONG_HOLD;
      pop <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_mode_left <= $urandom_range(16, 128);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0:       pop <= 1'b1;
        1:       pop <= 1'($urandom_range(0, 1));
        2:       pop <= ($urandom_range(0, 7) == 0);
        default: pop <= (rx_tick[1:0] != 2'd0);
      endcase
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Compare each command taken from the block with the oldest prediction
  always @(posedge clk) begin
    command_t want;
    if (!rst && pop && !empty) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: command of kind %0d with none predicted", $time, kind);
        err_cnt++;
      end else begin
        want = pending_cmds.pop_front();
        case (want.kind)
          rcpp_pkg::KIND_DRIVE: n_drive++;
          rcpp_pkg::KIND_GAIN:  n_gain++;
          rcpp_pkg::KIND_ESTOP: n_estop++;
          default:              n_param++;
        endcase
        check_field("kind", want.kind, kind);
        check_field("forward_velocity", want.fwd, $unsigned(forward_velocity));
        check_field("turn_rate", want.turn, $unsigned(turn_rate));
        check_field("vel_gain", want.gain, vel_gain);
        check_field("param_tag", want.tag, param_tag);
        check_field("param_size", want.len, param_size);
        check_field("param_index", want.idx, param_index);
        check_field("param_byte", want.data, param_byte);
        check_field("last", want.last, last);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed table: stray byte, every button, both parameter shapes, extreme axes
    add_row(8'h00);
    add_row(rcpp_pkg::CHAR_BUTTON);
    add_row(rcpp_pkg::CHAR_GAIN_UP, 1'b1,
            mk_cmd(rcpp_pkg::KIND_GAIN, 7'd11, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    add_row(rcpp_pkg::CHAR_BUTTON);
    add_row(rcpp_pkg::CHAR_GAIN_DOWN, 1'b1,
            mk_cmd(rcpp_pkg::KIND_GAIN, 7'd10, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    add_row(rcpp_pkg::CHAR_BUTTON);
    add_row(rcpp_pkg::CHAR_ESTOP, 1'b1,
            mk_cmd(rcpp_pkg::KIND_ESTOP, 7'd10, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    add_row(rcpp_pkg::CHAR_BUTTON);
    add_row(8'h78);
    add_row(rcpp_pkg::CHAR_PARAM);
    add_row(8'hA5);
    add_row(8'h00, 1'b1,
            mk_cmd(rcpp_pkg::KIND_PARAM_EMPTY, 7'd10, 8'hA5, 8'h00, 8'h00, 8'h00, 1'b1));
    add_row(rcpp_pkg::CHAR_PARAM);
    add_row(8'h5A);
    add_row(8'h01);
    add_row(8'hFF, 1'b1,
            mk_cmd(rcpp_pkg::KIND_PARAM_BYTE, 7'd10, 8'h5A, 8'h01, 8'h00, 8'hFF, 1'b1));
    add_row(rcpp_pkg::CHAR_JOY);
    repeat (4) add_row(rcpp_pkg::CHAR_ZERO + 8'd9);
    repeat (3) add_row(8'h2C);
    repeat (4) add_row(rcpp_pkg::CHAR_ZERO);
    add_row(8'h0D);
    add_row(8'h0A);
    foreach (directed_rows[i])
      send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
    drain();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       configure(7'd127, 8'd255, 16'd1);
        1:       configure(7'd0, 8'd0, 16'd65535);
        2:       configure(7'($urandom), 8'($urandom), 16'd0);
        3:       configure(7'd1, 8'd255, 16'd65535);
        default: configure(7'($urandom), 8'($urandom), 16'($urandom_range(1, 65535)));
      endcase
      // stall the receiver while the sender keeps pushing, so the block backs up
      if (ph == 3) begin
        hold_reqs <= hold_reqs + 1;
        no_gaps = 1'b1;
        for (int i = 0; i < 20; i++) begin
          feed(rcpp_pkg::CHAR_BUTTON);
          feed(i[0] ? rcpp_pkg::CHAR_GAIN_DOWN : rcpp_pkg::CHAR_GAIN_UP);
        end
        no_gaps = 1'b0;
      end
      for (int target = bytes_sent + PHASE_BYTES; bytes_sent < target; )
        send_random_packet();
      drain();
    end

    $display("Sent %0d bytes; checked %0d drive, %0d gain, %0d stop, %0d parameter commands",
             bytes_sent, n_drive, n_gain, n_estop, n_param);
    $display("Covered %0d register settings including reset values and both extremes",
             settings_used);
    if (err_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
